// ===== sv/sgsm_pkg.sv =====
package sgsm_pkg;

    localparam int VOCAB_MAX_DEF = 64;
    localparam int DIM_MAX_DEF   = 16;

    localparam int VOCAB_REG_W = 7;
    localparam int DIM_REG_W   = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam int ELEM_W   = 16;
    localparam int LOGIT_W  = 32;
    localparam int PROB_W   = 16;
    localparam int WORD_W   = 6;
    localparam int DIMI_W   = 4;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = 17;
    localparam int EXP_W    = 28;
    localparam int SUM_W    = 34;
    localparam int DVD_W    = EXP_W + 16;

    localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;

    localparam logic [KIND_W-1:0] KIND_WR_CENTER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_CONTEXT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [WORD_W-1:0]        word_index;
        logic [DIMI_W-1:0]        dim_index;
        logic signed [ELEM_W-1:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]         out_word;
        logic signed [LOGIT_W-1:0] logit;
        logic [PROB_W-1:0]         probability;
        logic                      last;
        logic                      bad_word;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DOT,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_SAT,
        ST_MUL,
        ST_EXP,
        ST_RD,
        ST_DIVS,
        ST_DIVW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic wr_center;
        logic wr_context;
        logic query_load;
        logic issue;
        logic acc_clear;
        logic sat_load;
        logic mul_load;
        logic exp_load;
        logic sum_clear;
        logic div_start;
        logic out_load;
        logic out_err;
        logic out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

    typedef logic [ENTRY_W-1:0] rom_t [256];

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k < 256; k++) begin
            z = (64'(k) * LN2_Q30) >> 8;
            term = 64'd1 << 30;
            sum = term;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * z) >> 30) / 64'(n);
                sum = sum + term;
            end
            r[k] = ENTRY_W'((sum + (64'd1 << 13)) >> 14);
        end
        return r;
    endfunction

    localparam rom_t POW2_ROM = build_rom();

endpackage

// ===== sv/sgsm_ram.sv =====
module sgsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sgsm_div.sv =====
module sgsm_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [sgsm_pkg::DVD_W-1:0] dividend,
    input  logic [sgsm_pkg::SUM_W-1:0] divisor,
    output logic [sgsm_pkg::DVD_W-1:0] quotient,
    output logic                    done
);
    import sgsm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [SUM_W-1:0] dsr_reg, dsr_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   rem_sh;
    logic [SUM_W:0]   rem_sub;

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rem_sub[SUM_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[SUM_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

// ===== sv/sgsm_ctrl.sv =====
module sgsm_ctrl #(
    parameter int VOCAB_MAX = sgsm_pkg::VOCAB_MAX_DEF,
    parameter int DIM_MAX   = sgsm_pkg::DIM_MAX_DEF,
    localparam int VW = $clog2(VOCAB_MAX),
    localparam int DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sgsm_pkg::in_item_t                s_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sgsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output sgsm_pkg::ctrl_cmd_t               cmd,
    input  sgsm_pkg::ctrl_stat_t              stat,
    output logic [VW-1:0]                     w_idx,
    output logic [DW-1:0]                     d_idx
);
    import sgsm_pkg::*;

    localparam int CW  = $clog2(VOCAB_MAX + 1);
    localparam int DCW = $clog2(DIM_MAX + 1);

    state_t                 state_reg, state_next;
    logic [VW-1:0]          w_reg, w_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [VOCAB_REG_W-1:0] vocab_reg;
    logic [DIM_REG_W-1:0]   dim_reg;
    logic [CW-1:0]          vocab_eff;
    logic [DCW-1:0]         dims_eff;
    logic                   bad_query;
    logic                   last_w;
    logic                   last_d;

    always_comb begin
        if (vocab_reg == '0) begin
            vocab_eff = CW'(1);
        end else if (32'(vocab_reg) > VOCAB_MAX) begin
            vocab_eff = CW'(VOCAB_MAX);
        end else begin
            vocab_eff = CW'(vocab_reg);
        end
        if (dim_reg == '0) begin
            dims_eff = DCW'(1);
        end else if (32'(dim_reg) > DIM_MAX) begin
            dims_eff = DCW'(DIM_MAX);
        end else begin
            dims_eff = DCW'(dim_reg);
        end
    end

    assign bad_query = 32'(s_data.word_index) >= 32'(vocab_eff);
    assign last_w    = 32'(w_reg) == 32'(vocab_eff) - 32'd1;
    assign last_d    = 32'(d_reg) == 32'(dims_eff) - 32'd1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_reg <= VOCAB_REG_W'(64);
            dim_reg   <= DIM_REG_W'(16);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VOCAB: vocab_reg <= cfg_data;
                CFG_DIM:   dim_reg   <= cfg_data[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        w_next     = w_reg;
        d_next     = d_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.kind == KIND_QUERY) begin
                    w_next = '0;
                    d_next = '0;
                    state_next = bad_query ? ST_ERR : ST_DOT;
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DOT: begin
                if (last_d) begin
                    d_next = '0;
                    state_next = ST_DRAIN1;
                end else begin
                    d_next = d_reg + DW'(1);
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_SAT;
            ST_SAT:    state_next = ST_MUL;
            ST_MUL:    state_next = ST_EXP;
            ST_EXP: begin
                if (last_w) begin
                    w_next = '0;
                    state_next = ST_RD;
                end else begin
                    w_next = w_reg + VW'(1);
                    state_next = ST_DOT;
                end
            end
            ST_RD:   state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: begin
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    if (last_w) begin
                        state_next = ST_IDLE;
                    end else begin
                        w_next = w_reg + VW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.wr_center  = s_data.kind == KIND_WR_CENTER;
                    cmd.wr_context = s_data.kind == KIND_WR_CONTEXT;
                    cmd.query_load = s_data.kind == KIND_QUERY;
                    cmd.acc_clear  = s_data.kind == KIND_QUERY;
                    cmd.sum_clear  = s_data.kind == KIND_QUERY;
                end
            end
            ST_ERR: begin
                cmd.out_load = stat.out_free;
                cmd.out_err  = 1'b1;
            end
            ST_DOT: cmd.issue = 1'b1;
            ST_SAT: cmd.sat_load = 1'b1;
            ST_MUL: cmd.mul_load = 1'b1;
            ST_EXP: begin
                cmd.exp_load  = 1'b1;
                cmd.acc_clear = 1'b1;
            end
            ST_DIVS: cmd.div_start = 1'b1;
            ST_OUT: begin
                cmd.out_load = stat.out_free;
                cmd.out_last = last_w;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            w_reg     <= '0;
            d_reg     <= '0;
        end else begin
            state_reg <= state_next;
            w_reg     <= w_next;
            d_reg     <= d_next;
        end
    end

    assign w_idx = w_reg;
    assign d_idx = d_reg;

endmodule

// ===== sv/sgsm_datapath.sv =====
module sgsm_datapath #(
    parameter int VOCAB_MAX = sgsm_pkg::VOCAB_MAX_DEF,
    parameter int DIM_MAX   = sgsm_pkg::DIM_MAX_DEF,
    localparam int VW = $clog2(VOCAB_MAX),
    localparam int DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sgsm_pkg::in_item_t   s_data,
    input  sgsm_pkg::ctrl_cmd_t  cmd,
    output sgsm_pkg::ctrl_stat_t stat,
    input  logic [VW-1:0]        w_idx,
    input  logic [DW-1:0]        d_idx,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sgsm_pkg::out_item_t  m_data
);
    import sgsm_pkg::*;

    localparam int TAB_DEPTH = VOCAB_MAX * DIM_MAX;
    localparam int AW        = $clog2(TAB_DEPTH);
    localparam int ACC_W     = LOGIT_W + DW;

    logic [WORD_W-1:0]          qword_reg;
    logic                       in_range;
    logic [AW-1:0]              wr_addr, ctr_addr, ctx_addr;
    logic [ELEM_W-1:0]          ctr_q, ctx_q;
    logic                       v1_reg, v2_reg;
    logic signed [31:0]         prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [LOGIT_W-1:0]  logit_sat;
    logic signed [LOGIT_W-1:0]  logit_reg;
    logic signed [63:0]         p_reg;
    logic [19:0]                u_val;
    logic [ENTRY_W-1:0]         entry;
    logic [EXP_W-1:0]           exp_val;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [LOGIT_W-1:0]         lg_q;
    logic [EXP_W-1:0]           ex_q;
    logic [LOGIT_W-1:0]         lg_hold_reg;
    logic [DVD_W-1:0]           quot;
    logic                       div_done;
    logic [PROB_W-1:0]          prob;
    logic                       m_valid_reg;
    out_item_t                  m_data_reg;
    logic [31:0]                w_ext;

    assign in_range = (32'(s_data.word_index) < VOCAB_MAX) && (32'(s_data.dim_index) < DIM_MAX);
    assign wr_addr  = AW'(32'(s_data.word_index) * DIM_MAX + 32'(s_data.dim_index));
    assign ctr_addr = AW'(32'(qword_reg) * DIM_MAX + 32'(d_idx));
    assign ctx_addr = AW'(32'(w_idx) * DIM_MAX + 32'(d_idx));

    sgsm_ram #(.WIDTH(ELEM_W), .DEPTH(TAB_DEPTH)) u_center (
        .aclk(aclk), .we(cmd.wr_center && in_range), .waddr(wr_addr),
        .wdata(s_data.elem_value), .raddr(ctr_addr), .rdata(ctr_q)
    );

    sgsm_ram #(.WIDTH(ELEM_W), .DEPTH(TAB_DEPTH)) u_context (
        .aclk(aclk), .we(cmd.wr_context && in_range), .waddr(wr_addr),
        .wdata(s_data.elem_value), .raddr(ctx_addr), .rdata(ctx_q)
    );

    sgsm_ram #(.WIDTH(LOGIT_W), .DEPTH(VOCAB_MAX)) u_logit (
        .aclk(aclk), .we(cmd.sat_load), .waddr(w_idx),
        .wdata(logit_sat), .raddr(w_idx), .rdata(lg_q)
    );

    sgsm_ram #(.WIDTH(EXP_W), .DEPTH(VOCAB_MAX)) u_exp (
        .aclk(aclk), .we(cmd.exp_load), .waddr(w_idx),
        .wdata(exp_val), .raddr(w_idx), .rdata(ex_q)
    );

    sgsm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend({ex_q, 16'd0}), .divisor(sum_reg),
        .quotient(quot), .done(div_done)
    );

    always_comb begin
        if (acc_reg > ACC_W'(64'sd2147483647)) begin
            logit_sat = 32'sh7FFFFFFF;
        end else if (acc_reg < -ACC_W'(64'sd2147483648)) begin
            logit_sat = 32'sh80000000;
        end else begin
            logit_sat = acc_reg[LOGIT_W-1:0];
        end
    end

    always_comb begin
        if (p_reg[63] && !(&p_reg[63:57])) begin
            u_val = 20'h00000;
        end else if (!p_reg[63] && (|p_reg[63:57])) begin
            u_val = 20'hFFFFF;
        end else begin
            u_val = {~p_reg[57], p_reg[56:38]};
        end
        entry = POW2_ROM[u_val[15:8]];
        if (u_val[19]) begin
            exp_val = EXP_W'(entry) << u_val[18:16];
        end else begin
            exp_val = EXP_W'(entry) >> (4'd8 - u_val[19:16]);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_clear) begin
            acc_next = '0;
        end else if (v2_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        sum_next = sum_reg;
        if (cmd.sum_clear) begin
            sum_next = '0;
        end else if (cmd.exp_load) begin
            sum_next = sum_reg + SUM_W'(exp_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sum_reg <= '0;
        end else begin
            v1_reg  <= cmd.issue;
            v2_reg  <= v1_reg;
            sum_reg <= sum_next;
        end
        acc_reg <= acc_next;
        if (cmd.query_load) begin
            qword_reg <= s_data.word_index;
        end
        if (v1_reg) begin
            prod_reg <= $signed(ctr_q) * $signed(ctx_q);
        end
        if (cmd.sat_load) begin
            logit_reg <= logit_sat;
        end
        if (cmd.mul_load) begin
            p_reg <= 64'(logit_reg) * $signed(LOG2E_Q30);
        end
        if (cmd.div_start) begin
            lg_hold_reg <= lg_q;
        end
    end

    assign prob  = (sum_reg == '0) ? '0 :
                   ((quot > DVD_W'(65535)) ? 16'hFFFF : quot[PROB_W-1:0]);
    assign w_ext = 32'(w_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            if (cmd.out_err) begin
                m_data_reg.out_word    <= qword_reg;
                m_data_reg.logit       <= '0;
                m_data_reg.probability <= '0;
                m_data_reg.last        <= 1'b1;
                m_data_reg.bad_word    <= 1'b1;
            end else begin
                m_data_reg.out_word    <= w_ext[WORD_W-1:0];
                m_data_reg.logit       <= lg_hold_reg;
                m_data_reg.probability <= prob;
                m_data_reg.last        <= cmd.out_last;
                m_data_reg.bad_word    <= 1'b0;
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

// ===== sv/skipgram_logits_softmax_unit.sv =====
// Skip-gram logits and softmax engine.
// s_ channel: one transaction per table write or query (kind field).
//   Table writes produce no result.
//   A query emits one result per word in use on the m_ channel, the final
//   one flagged last; an out-of-range center word gives one error result.
// cfg channel: always ready, takes vocab_in_use (index 0) and dim_in_use
//   (index 1); write only while the block is idle.
// Query: the dot products run one product a cycle through the table read
//   ports and the multiplier, and the probabilities come from the
//   bit-serial 44-step divider; s_ready is low for the whole query.
// Receiver stall: results sit in the output register; the divider for the
//   next word runs meanwhile, then the sequencer holds until the slot frees.
// Reset: aresetn (synchronous, active low) idles the sequencer, empties the
//   output register, restores the register defaults and clears the exp sum.
//   Table contents are not cleared and must be written before use.
module skipgram_logits_softmax_unit #(
    parameter int VOCAB_MAX = sgsm_pkg::VOCAB_MAX_DEF,
    parameter int DIM_MAX   = sgsm_pkg::DIM_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sgsm_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sgsm_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sgsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgsm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sgsm_pkg::*;

    localparam int VW = $clog2(VOCAB_MAX);
    localparam int DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

    ctrl_cmd_t     cmd;
    ctrl_stat_t    stat;
    logic [VW-1:0] w_idx;
    logic [DW-1:0] d_idx;

    sgsm_ctrl #(.VOCAB_MAX(VOCAB_MAX), .DIM_MAX(DIM_MAX)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat), .w_idx(w_idx), .d_idx(d_idx)
    );

    sgsm_datapath #(.VOCAB_MAX(VOCAB_MAX), .DIM_MAX(DIM_MAX)) u_datapath (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data),
        .cmd(cmd), .stat(stat), .w_idx(w_idx), .d_idx(d_idx),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ===== sim/skipgram_logits_softmax_unit_tb.sv =====
module skipgram_logits_softmax_unit_tb;
    import sgsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    skipgram_logits_softmax_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    logic [16:0]    pow2_lut [256];
    int             center_rows [64][16];
    int             context_rows [64][16];
    int unsigned    vocab_reg;
    int unsigned    dim_reg;
    out_item_t      pending_results [$];
    bit             failed;
    bit             no_gaps;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("skipgram_logits_softmax_unit_tb NOT OK");
        $finish;
    end

    function automatic void build_pow2_lut();
        longint unsigned z, term, acc;
        for (int k = 0; k < 256; k++) begin
            z = (longint'(k) * 64'd744261118) >> 8;
            term = 64'd1 << 30;
            acc = term;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * z) >> 30) / n;
                acc += term;
            end
            pow2_lut[k] = 17'((acc + (64'd1 << 13)) >> 14);
        end
    endfunction

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned exp_of_logit(longint lg);
        longint      p, y;
        int unsigned u, k;
        int          sh;
        p = lg * 64'sd1549082005;
        y = p >>> 38;
        if (y < -524288) y = -524288;
        if (y > 524287) y = 524287;
        u = int'(y + 524288);
        sh = int'(u >> 16) - 8;
        k = (u >> 8) & 255;
        if (sh >= 0) return longint'(pow2_lut[k]) << sh;
        return longint'(pow2_lut[k]) >> (-sh);
    endfunction

    function automatic void predict_softmax(in_item_t it);
        int unsigned     vocab, dims;
        longint          logits [64];
        longint unsigned exps [64];
        longint unsigned total, prob;
        out_item_t       r;
        vocab = clamp_reg(vocab_reg, 64);
        dims = clamp_reg(dim_reg, 16);
        case (it.kind)
            KIND_WR_CENTER: center_rows[it.word_index][it.dim_index] = it.elem_value;
            KIND_WR_CONTEXT: context_rows[it.word_index][it.dim_index] = it.elem_value;
            KIND_QUERY: begin
                if (it.word_index >= vocab) begin
                    r = '0;
                    r.out_word = it.word_index;
                    r.last = 1'b1;
                    r.bad_word = 1'b1;
                    pending_results.push_back(r);
                end else begin
                    total = 0;
                    for (int w = 0; w < vocab; w++) begin
                        logits[w] = 0;
                        for (int d = 0; d < dims; d++)
                            logits[w] += longint'(center_rows[it.word_index][d]) *
                                         longint'(context_rows[w][d]);
                        if (logits[w] > 64'sd2147483647) logits[w] = 64'sd2147483647;
                        if (logits[w] < -64'sd2147483648) logits[w] = -64'sd2147483648;
                        exps[w] = exp_of_logit(logits[w]);
                        total += exps[w];
                    end
                    for (int w = 0; w < vocab; w++) begin
                        prob = (total != 0) ? (exps[w] << 16) / total : 0;
                        if (prob > 65535) prob = 65535;
                        r.out_word = 6'(w);
                        r.logit = 32'(logits[w]);
                        r.probability = 16'(prob);
                        r.last = (w + 1 == vocab);
                        r.bad_word = 1'b0;
                        pending_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_softmax(it);
    endtask

    task automatic send_fields(logic [KIND_W-1:0] kind, int word, int dim, int val);
        in_item_t it;
        it.kind = kind;
        it.word_index = 6'(word);
        it.dim_index = 4'(dim);
        it.elem_value = 16'(val);
        send_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 7'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_VOCAB) vocab_reg = value & 7'h7F;
        else dim_reg = value & 5'h1F;
        @(posedge aclk);
    endtask

    function automatic int rand_elem();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic test_table_fill();
        no_gaps = 1'b1;
        for (int w = 0; w < 64; w++) begin
            send_fields(KIND_WR_CENTER, w, 0, rand_elem());
            send_fields(KIND_WR_CONTEXT, w, 0, rand_elem());
        end
        for (int w = 0; w < 8; w++)
            for (int d = 1; d < 4; d++) begin
                send_fields(KIND_WR_CENTER, w, d, rand_elem());
                send_fields(KIND_WR_CONTEXT, w, d, rand_elem());
            end
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_directed();
        write_reg(CFG_VOCAB, 4);
        write_reg(CFG_DIM, 4);
        for (int d = 0; d < 4; d++) begin
            send_fields(KIND_WR_CENTER, 0, d, 32767);
            send_fields(KIND_WR_CONTEXT, 1, d, -32768);
        end
        send_fields(KIND_WR_CONTEXT, 0, 3, 32767);
        send_fields(KIND_QUERY, 0, 0, 0);
        send_fields(KIND_QUERY, 3, 15, -1);
        send_fields(KIND_QUERY, 4, 0, 0);
        send_fields(KIND_QUERY, 63, 0, 0);
        send_fields(KIND_NOP, 63, 15, -32768);
        send_fields(KIND_QUERY, 1, 0, 0);
        drain();
    endtask

    task automatic test_dim_clamp();
        write_reg(CFG_VOCAB, 1);
        write_reg(CFG_DIM, 31);
        for (int d = 4; d < 16; d++) begin
            send_fields(KIND_WR_CENTER, 0, d, 32767);
            send_fields(KIND_WR_CONTEXT, 0, d, 32767);
        end
        send_fields(KIND_QUERY, 0, 0, 0);
        send_fields(KIND_QUERY, 5, 0, 0);
        send_fields(KIND_QUERY, 0, 7, 1);
        drain();
    endtask

    task automatic test_random(int unsigned vocab, int unsigned dims, int count);
        int unsigned eff;
        int          sel;
        write_reg(CFG_VOCAB, vocab);
        write_reg(CFG_DIM, dims);
        eff = clamp_reg(vocab_reg, 64);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                drain();
                no_gaps = ~no_gaps;
            end
            sel = $urandom_range(0, 19);
            if (sel < 10)
                send_fields(sel[0] ? KIND_WR_CONTEXT : KIND_WR_CENTER,
                            $urandom_range(0, 63), $urandom_range(0, 15), rand_elem());
            else if (sel < 17)
                send_fields(KIND_QUERY, $urandom_range(0, eff - 1),
                            $urandom_range(0, 15), rand_elem());
            else if (sel < 19 && eff < 64)
                send_fields(KIND_QUERY, $urandom_range(eff, 63),
                            $urandom_range(0, 15), rand_elem());
            else
                send_fields(KIND_NOP, $urandom_range(0, 63),
                            $urandom_range(0, 15), rand_elem());
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial begin
        int n;
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 13);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%t unexpected result %p", $realtime, m_data);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    $display("%t expected %p actual %p", $realtime, want, m_data);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        no_gaps = 1'b0;
        vocab_reg = 64;
        dim_reg = 16;
        build_pow2_lut();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_fill();
        test_directed();
        test_dim_clamp();
        test_random(64, 1, 8);
        test_random(1, 1, 6);
        test_random(0, 0, 6);
        test_random(127, 1, 6);
        test_random(8, 4, 24);
        test_random($urandom_range(2, 8), $urandom_range(1, 4), 20);
        if (!failed && pending_results.size() == 0)
            $display("skipgram_logits_softmax_unit_tb OK");
        else
            $display("skipgram_logits_softmax_unit_tb NOT OK");
        $finish;
    end
endmodule

// ===== skipgram_logits_softmax_unit.f =====
sv/sgsm_pkg.sv
sv/sgsm_ram.sv
sv/sgsm_div.sv
sv/sgsm_ctrl.sv
sv/sgsm_datapath.sv
sv/skipgram_logits_softmax_unit.sv
sim/skipgram_logits_softmax_unit_tb.sv
